// ===== rtl/pmst_pkg.sv =====
// Shared types and constants for the Prim spanning-tree block.
// Holds the mode codes, the controller states and the command/status structs.
// No dependencies.
package pmst_pkg;

    localparam int MAX_NODES_DEF   = 16;
    localparam int WEIGHT_BITS_DEF = 16;

    // fixed port field widths
    localparam int MODE_W   = 2;
    localparam int NODE_W   = 4;
    localparam int WEIGHT_W = 16;
    localparam int COST_W   = 20;
    localparam int NCNT_W   = 5;

    localparam logic [NCNT_W-1:0] NCNT_RST = 5'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD  = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SEED,
        S_SEED_END,
        S_SEED_EMIT,
        S_INIT_A,
        S_INIT_B,
        S_INIT_C,
        S_SEL,
        S_SEL_END,
        S_SEL_EMIT,
        S_UPD_A,
        S_UPD_B,
        S_UPD_C
    } t_state;

    typedef struct packed {
        logic clr_wr;     // write no-edge at the sweep address
        logic load_wr;    // write the accepted edge
        logic run_start;  // latch node count, zero the running total
        logic scan_clr;   // restart a minimum scan
        logic idx_clr;    // restart the node index
        logic seed_rd;    // read (i,j) for the seed scan
        logic sel_rd;     // read (i,nearest[i]) for the selection scan
        logic nb_rd1;     // first read of a nearest-node step
        logic nb_rd2;     // second read of a nearest-node step
        logic nb_cmp;     // compare and write nearest[i]
        logic nb_init;    // nearest-node step belongs to the init pass
        logic emit_edge;
        logic emit_disc;
        logic emit_last;
        logic round_init;
        logic round_inc;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic last_i;
        logic last_j;
        logic found;
        logic out_free;
        logic n_is2;
        logic round_last;
    } t_status;

endpackage

// ===== rtl/pmst_ctrl.sv =====
// Sequencer for the Prim spanning-tree block: clear sweep, loads, seed scan,
// nearest-node passes and selection rounds.
// Depends on pmst_pkg.
module pmst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_mode,
    output logic              o_in_ready,
    input  pmst_pkg::t_status i_sts,
    output pmst_pkg::t_cmd    o_cmd
);
    import pmst_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state) inside
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_mode)
                        MODE_LOAD: o_cmd.load_wr = 1'b1;
                        MODE_RUN: begin
                            o_cmd.run_start = 1'b1;
                            o_cmd.scan_clr  = 1'b1;
                            n_state         = S_SEED;
                        end
                        MODE_CLEAR: n_state = S_CLEAR;
                        default: ;
                    endcase
                end
            end
            S_SEED: begin
                o_cmd.seed_rd = 1'b1;
                if (i_sts.last_i && i_sts.last_j) n_state = S_SEED_END;
            end
            // last read data lands in the compare stage
            S_SEED_END: n_state = S_SEED_EMIT;
            S_SEED_EMIT: begin
                if (i_sts.out_free) begin
                    if (!i_sts.found) begin
                        o_cmd.emit_disc = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        o_cmd.emit_edge = 1'b1;
                        o_cmd.emit_last = i_sts.n_is2;
                        if (i_sts.n_is2) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.idx_clr = 1'b1;
                            n_state       = S_INIT_A;
                        end
                    end
                end
            end
            S_INIT_A, S_UPD_A: begin
                o_cmd.nb_rd1  = 1'b1;
                o_cmd.nb_init = (r_state == S_INIT_A);
                n_state       = (r_state == S_INIT_A) ? S_INIT_B : S_UPD_B;
            end
            S_INIT_B, S_UPD_B: begin
                o_cmd.nb_rd2  = 1'b1;
                o_cmd.nb_init = (r_state == S_INIT_B);
                n_state       = (r_state == S_INIT_B) ? S_INIT_C : S_UPD_C;
            end
            S_INIT_C, S_UPD_C: begin
                o_cmd.nb_cmp  = 1'b1;
                o_cmd.nb_init = (r_state == S_INIT_C);
                if (i_sts.last_i) begin
                    o_cmd.scan_clr   = 1'b1;
                    o_cmd.round_init = (r_state == S_INIT_C);
                    o_cmd.round_inc  = (r_state == S_UPD_C);
                    n_state          = S_SEL;
                end else begin
                    n_state = (r_state == S_INIT_C) ? S_INIT_A : S_UPD_A;
                end
            end
            S_SEL: begin
                o_cmd.sel_rd = 1'b1;
                if (i_sts.last_i) n_state = S_SEL_END;
            end
            S_SEL_END: n_state = S_SEL_EMIT;
            S_SEL_EMIT: begin
                if (i_sts.out_free) begin
                    if (!i_sts.found) begin
                        o_cmd.emit_disc = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        o_cmd.emit_edge = 1'b1;
                        o_cmd.emit_last = i_sts.round_last;
                        if (i_sts.round_last) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.idx_clr = 1'b1;
                            n_state       = S_UPD_A;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/pmst_dp.sv =====
// Datapath for the Prim spanning-tree block: weight memory, scan counters,
// minimum tracker, nearest-node table, running total and result register.
// Depends on pmst_pkg; driven by pmst_ctrl commands.
module pmst_dp #(
    parameter int MAX_NODES   = pmst_pkg::MAX_NODES_DEF,
    parameter int WEIGHT_BITS = pmst_pkg::WEIGHT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pmst_pkg::t_cmd                i_cmd,
    output pmst_pkg::t_status             o_sts,
    input  logic [pmst_pkg::NODE_W-1:0]   i_node_a,
    input  logic [pmst_pkg::NODE_W-1:0]   i_node_b,
    input  logic [pmst_pkg::WEIGHT_W-1:0] i_weight,
    input  logic                          i_cfg_valid,
    input  logic [pmst_pkg::NCNT_W-1:0]   i_cfg_node_count,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pmst_pkg::NODE_W-1:0]   o_from_node,
    output logic [pmst_pkg::NODE_W-1:0]   o_to_node,
    output logic [pmst_pkg::WEIGHT_W-1:0] o_edge_weight,
    output logic [pmst_pkg::COST_W-1:0]   o_total_cost,
    output logic                          o_disconnected,
    output logic                          o_last
);
    import pmst_pkg::*;

    localparam int IDX_W  = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam logic [WEIGHT_BITS-1:0] NO_EDGE = {WEIGHT_BITS{1'b1}};

    // upper-triangle address: both directions of an edge share one entry
    function automatic logic [ADDR_W-1:0] canon(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
        return (a < b) ? {a, b} : {b, a};
    endfunction

    logic [WEIGHT_BITS-1:0] r_mem [DEPTH];
    logic [WEIGHT_BITS-1:0] r_rd_data;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      r_clr_addr;

    logic [NCNT_W-1:0]      r_node_count;
    logic [IDX_W-1:0]       nm1;
    logic [IDX_W-1:0]       r_nm1;
    logic [IDX_W-1:0]       r_i;
    logic [IDX_W-1:0]       r_j;
    logic [IDX_W-1:0]       r_round;

    logic                   r_pend;
    logic                   r_pelig;
    logic [IDX_W-1:0]       r_pa;
    logic [IDX_W-1:0]       r_pb;
    logic                   cand;

    logic [WEIGHT_BITS-1:0] r_best;
    logic                   r_found;
    logic [IDX_W-1:0]       r_sel_a;
    logic [IDX_W-1:0]       r_sel_b;
    logic [WEIGHT_BITS-1:0] r_w1;
    logic [IDX_W-1:0]       r_nearest [MAX_NODES];
    logic [MAX_NODES-1:0]   r_in_tree;
    logic [COST_W-1:0]      r_cost;
    logic [COST_W-1:0]      cost_sum;

    logic                   load_ok;
    logic [ADDR_W-1:0]      load_addr;
    logic [WEIGHT_BITS-1:0] load_w;

    logic                   r_out_valid;
    logic [NODE_W-1:0]      r_from;
    logic [NODE_W-1:0]      r_to;
    logic [WEIGHT_W-1:0]    r_eweight;
    logic [COST_W-1:0]      r_total;
    logic                   r_disc;
    logic                   r_last;

    // edge load; self-loops and out-of-range endpoints are dropped
    assign load_ok   = i_cmd.load_wr && (i_node_a != i_node_b)
                       && (32'(i_node_a) < MAX_NODES) && (32'(i_node_b) < MAX_NODES);
    assign load_addr = canon(IDX_W'(i_node_a), IDX_W'(i_node_b));
    assign load_w    = WEIGHT_BITS'(i_weight);

    always_comb begin
        rd_addr = canon(r_i, r_j);
        if (i_cmd.sel_rd) begin
            rd_addr = canon(r_i, r_nearest[r_i]);
        end else if (i_cmd.nb_rd1) begin
            rd_addr = canon(r_sel_a, r_i);
        end else if (i_cmd.nb_rd2) begin
            rd_addr = canon(i_cmd.nb_init ? r_sel_b : r_nearest[r_i], r_i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_mem[r_clr_addr] <= NO_EDGE;
        end else if (load_ok) begin
            r_mem[load_addr] <= load_w;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // node count saturates to 2..MAX_NODES when a run starts
    always_comb begin
        if (r_node_count < NCNT_W'(2)) begin
            nm1 = IDX_W'(1);
        end else if (32'(r_node_count) > MAX_NODES) begin
            nm1 = IDX_W'(MAX_NODES - 1);
        end else begin
            nm1 = IDX_W'(r_node_count - NCNT_W'(1));
        end
    end

    assign cand     = r_pend && r_pelig && (r_rd_data < r_best);
    assign cost_sum = r_cost + COST_W'(r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr   <= '0;
            r_node_count <= NCNT_RST;
            r_pend       <= 1'b0;
            r_in_tree    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (i_cfg_valid) r_node_count <= i_cfg_node_count;
            r_pend <= i_cmd.seed_rd || i_cmd.sel_rd;
            if (i_cmd.nb_cmp && i_cmd.nb_init) begin
                r_in_tree[r_i] <= (r_i == r_sel_a) || (r_i == r_sel_b);
            end else if (i_cmd.emit_edge) begin
                r_in_tree[r_sel_a] <= 1'b1;
            end
            if (i_cmd.emit_edge || i_cmd.emit_disc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.run_start) r_nm1 <= nm1;

        if (i_cmd.scan_clr || i_cmd.idx_clr) begin
            r_i <= '0;
            r_j <= '0;
        end else if (i_cmd.seed_rd) begin
            if (r_j == r_nm1) begin
                r_j <= '0;
                r_i <= r_i + IDX_W'(1);
            end else begin
                r_j <= r_j + IDX_W'(1);
            end
        end else if (i_cmd.sel_rd || i_cmd.nb_cmp) begin
            r_i <= r_i + IDX_W'(1);
        end

        // candidate stage, registered in step with the read data
        r_pa    <= r_i;
        r_pb    <= i_cmd.seed_rd ? r_j : r_nearest[r_i];
        r_pelig <= i_cmd.seed_rd || !r_in_tree[r_i];

        if (i_cmd.scan_clr) begin
            r_best  <= NO_EDGE;
            r_found <= 1'b0;
        end else if (cand) begin
            r_best  <= r_rd_data;
            r_sel_a <= r_pa;
            r_sel_b <= r_pb;
            r_found <= 1'b1;
        end

        if (i_cmd.nb_rd2) r_w1 <= r_rd_data;
        if (i_cmd.nb_cmp) begin
            if (i_cmd.nb_init) begin
                r_nearest[r_i] <= (r_w1 < r_rd_data) ? r_sel_a : r_sel_b;
            end else if (!r_in_tree[r_i] && (r_w1 < r_rd_data)) begin
                r_nearest[r_i] <= r_sel_a;
            end
        end

        if (i_cmd.run_start) begin
            r_cost <= '0;
        end else if (i_cmd.emit_edge) begin
            r_cost <= cost_sum;
        end

        if (i_cmd.round_init) begin
            r_round <= IDX_W'(1);
        end else if (i_cmd.round_inc) begin
            r_round <= r_round + IDX_W'(1);
        end

        if (i_cmd.emit_edge) begin
            r_from    <= NODE_W'(r_sel_a);
            r_to      <= NODE_W'(r_sel_b);
            r_eweight <= WEIGHT_W'(r_best);
            r_total   <= cost_sum;
            r_disc    <= 1'b0;
            r_last    <= i_cmd.emit_last;
        end else if (i_cmd.emit_disc) begin
            r_from    <= '0;
            r_to      <= '0;
            r_eweight <= '0;
            r_total   <= r_cost;
            r_disc    <= 1'b1;
            r_last    <= 1'b1;
        end
    end

    assign o_sts.clr_done   = &r_clr_addr;
    assign o_sts.last_i     = (r_i == r_nm1);
    assign o_sts.last_j     = (r_j == r_nm1);
    assign o_sts.found      = r_found;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_sts.n_is2      = (r_nm1 == IDX_W'(1));
    assign o_sts.round_last = (r_round == r_nm1 - IDX_W'(1));

    assign o_out_valid    = r_out_valid;
    assign o_from_node    = r_from;
    assign o_to_node      = r_to;
    assign o_edge_weight  = r_eweight;
    assign o_total_cost   = r_total;
    assign o_disconnected = r_disc;
    assign o_last         = r_last;

endmodule

// ===== rtl/prim_mst_adjacency_matrix.sv =====
// Top level of the Prim minimum spanning tree block over a weight matrix.
// Instantiates pmst_ctrl and pmst_dp; depends on pmst_pkg.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready) carries mode, node_a, node_b, weight.
//   Mode load writes one undirected edge, so loads stream at one transaction
//   per cycle. Mode clear resets every entry to no-edge with a sweep of all
//   2^(2*ceil(log2 MAX_NODES)) entries (256 at 16 nodes). Mode run builds
//   the tree over node_count nodes (config channel, reset value 2). A run
//   with n nodes scans all n*n pairs for the seed edge, makes one nearest-node
//   init pass, then per added node one selection scan and one update pass,
//   all through the single read port of the weight memory.
//   Results (o_out_valid/i_out_ready) come one per tree edge with a running
//   total, o_last on the final one, o_disconnected if the graph falls apart.
//   The result register holds while the receiver stalls; the run waits for it
//   to drain before emitting the next edge. Input is taken only between runs.
//   After reset the block sweeps the matrix to no-edge (same length as a
//   clear) before o_in_ready rises. Config writes are always accepted.
module prim_mst_adjacency_matrix #(
    parameter int MAX_NODES   = pmst_pkg::MAX_NODES_DEF,
    parameter int WEIGHT_BITS = pmst_pkg::WEIGHT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [pmst_pkg::MODE_W-1:0]   i_mode,
    input  logic [pmst_pkg::NODE_W-1:0]   i_node_a,
    input  logic [pmst_pkg::NODE_W-1:0]   i_node_b,
    input  logic [pmst_pkg::WEIGHT_W-1:0] i_weight,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pmst_pkg::NCNT_W-1:0]   i_cfg_node_count,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pmst_pkg::NODE_W-1:0]   o_from_node,
    output logic [pmst_pkg::NODE_W-1:0]   o_to_node,
    output logic [pmst_pkg::WEIGHT_W-1:0] o_edge_weight,
    output logic [pmst_pkg::COST_W-1:0]   o_total_cost,
    output logic                          o_disconnected,
    output logic                          o_last
);
    import pmst_pkg::*;

    t_cmd    cmd;
    t_status sts;

    assign o_cfg_ready = 1'b1;

    pmst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pmst_dp #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_node_a         (i_node_a),
        .i_node_b         (i_node_b),
        .i_weight         (i_weight),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_node_count (i_cfg_node_count),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_from_node      (o_from_node),
        .o_to_node        (o_to_node),
        .o_edge_weight    (o_edge_weight),
        .o_total_cost     (o_total_cost),
        .o_disconnected   (o_disconnected),
        .o_last           (o_last)
    );

endmodule

// ===== rtl/pmst_checker.sv =====
// Port-level checks for the Prim spanning-tree block, bound to its top level.
// Depends on pmst_pkg and prim_mst_adjacency_matrix.
module pmst_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [pmst_pkg::NODE_W-1:0]   o_from_node,
    input logic [pmst_pkg::NODE_W-1:0]   o_to_node,
    input logic [pmst_pkg::WEIGHT_W-1:0] o_edge_weight,
    input logic [pmst_pkg::COST_W-1:0]   o_total_cost,
    input logic                          o_disconnected,
    input logic                          o_last
);
    import pmst_pkg::*;

    // reset starts the clear sweep: no input taken, no result pending
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("input ready or result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_total_cost)
            && $stable(o_from_node) && $stable(o_to_node) && $stable(o_last))
        else $error("stalled result changed");

    a_disc_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_disconnected |-> o_last && o_from_node == '0
            && o_to_node == '0 && o_edge_weight == '0)
        else $error("disconnected result not final or fields not zero");

    a_edge_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_disconnected |-> o_from_node != o_to_node)
        else $error("tree edge is a self-loop");

endmodule

bind prim_mst_adjacency_matrix pmst_checker u_pmst_checker (.*);
